// ----- rtl/camera_pose_view_matrix_macros.svh -----
// Assertion macros for the camera pose view matrix block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CAMERA_POSE_VIEW_MATRIX_MACROS_SVH
`define CAMERA_POSE_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("camera pose view matrix: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("camera pose view matrix: check failed");

`endif

// ----- rtl/cpv_pkg.sv -----
// Types, codes and constant tables for the camera pose view matrix block.
// No dependencies; imported by camera_pose_view_matrix, cpv_view_checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package cpv_pkg;

	typedef enum logic [1:0] {
		OP_PLACE  = 2'd0,
		OP_MOVE   = 2'd1,
		OP_ROTATE = 2'd2,
		OP_VIEW   = 2'd3
	} op_t;

	localparam logic [1:0] DIR_FWD   = 2'd0;
	localparam logic [1:0] DIR_BACK  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// what the shared multiplier sequence computes
	typedef enum logic [2:0] {
		PM_CROSS,
		PM_DOT,
		PM_SQR,
		PM_MOVE,
		PM_ROT
	} pmode_t;

	localparam int PITCH_LIMIT_DEG = 89;
	localparam int ANG_BITS        = 24;
	localparam int VEC_BITS        = 30;
	localparam int CORDIC_STEPS    = 24;
	localparam int MOD_BASE        = 45;	// 360 degrees = 45 * 2^27 at 24 fraction bits

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] TURN_HALF   = 34'sd3019898880;
	localparam logic signed [33:0] TURN_FULL   = 34'sd6039797760;
	localparam logic signed [33:0] TURN_QUART  = 34'sd1509949440;

	// arctangent of 2^-i in degrees, 24 fraction bits
	function automatic logic [31:0] atan_deg(input logic [4:0] i);
		unique case (i)
			5'd0:    return 32'd754974720;
			5'd1:    return 32'd445687602;
			5'd2:    return 32'd235489088;
			5'd3:    return 32'd119537938;
			5'd4:    return 32'd60000934;
			5'd5:    return 32'd30029717;
			5'd6:    return 32'd15018523;
			5'd7:    return 32'd7509720;
			5'd8:    return 32'd3754917;
			5'd9:    return 32'd1877466;
			5'd10:   return 32'd938734;
			5'd11:   return 32'd469367;
			5'd12:   return 32'd234684;
			5'd13:   return 32'd117342;
			5'd14:   return 32'd58671;
			5'd15:   return 32'd29335;
			5'd16:   return 32'd14668;
			5'd17:   return 32'd7334;
			5'd18:   return 32'd3667;
			5'd19:   return 32'd1833;
			5'd20:   return 32'd917;
			5'd21:   return 32'd458;
			5'd22:   return 32'd229;
			5'd23:   return 32'd115;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// operand order of the six products of a cross product
	function automatic logic [1:0] cross_a_idx(input logic [2:0] pc);
		unique case (pc)
			3'd0:    return 2'd1;
			3'd1:    return 2'd2;
			3'd2:    return 2'd2;
			3'd3:    return 2'd0;
			3'd4:    return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] cross_b_idx(input logic [2:0] pc);
		unique case (pc)
			3'd0:    return 2'd2;
			3'd1:    return 2'd1;
			3'd2:    return 2'd0;
			3'd3:    return 2'd2;
			3'd4:    return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- rtl/camera_pose_view_matrix.sv -----
// Camera pose keeper and look-at view matrix generator, fixed point.
// Depends on cpv_pkg and camera_pose_view_matrix_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Request channel s_*: one camera event per request. s_tuser carries the
//  event code and move direction, s_tdata the speed, angles and the place pose.
//  Result channel m_*: one request per event with the three view matrix rows.
//  Config port: cfg_we/cfg_index/cfg_data write the world up vector (index 0..2,
//  higher indexes are dropped); write only while no event is in flight.
//  One event runs through a sequencer around one shared 32x32
//  multiplier, a one-bit-per-cycle square root, a restoring divider and a
//  CORDIC rotator.
//  s_tready is high only while the sequencer is idle; one event at a time.
//  The result sits in an output register: the next request is taken while it
//  waits, and a finished event holds until the slot frees when m_tready is low.
//  Reset: pose returns to position 0, target and front (0,0,-1), right (1,0,0),
//  up (0,1,0); no result is pending.

`include "camera_pose_view_matrix_macros.svh"

module camera_pose_view_matrix
	import cpv_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [1:0] op, [3:2] move_dir
	input  wire logic [3:0]   s_tuser,
	// [31:0] speed, pitch_deg, yaw_deg, pos_x, pos_y, pos_z, aim_x, aim_y, aim_z
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] side_x, side_y, side_z, side_shift, lift_x, lift_y, lift_z,
	// lift_shift, back_x, back_y, back_z, back_shift
	output logic [383:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int QW = FRAC_BITS + 1;            // normalized magnitude <= 2^FRAC_BITS
	localparam int NW = FRAC_BITS + 32;           // divider numerator
	localparam int IW = $clog2(FRAC_BITS + 1);
	localparam int ANG_SHIFT = ANG_BITS - FRAC_BITS;
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [31:0] ONE = 32'(2 ** FRAC_BITS);
	localparam logic signed [31:0] PITCH_LIM = 32'(PITCH_LIMIT_DEG * (2 ** FRAC_BITS));
	localparam logic [27:0] MOD_BIAS = 28'(MOD_BASE) << 21;

	typedef enum logic [4:0] {
		ST_IDLE, ST_P_FRONT, ST_R_DONE, ST_AIM, ST_T_YAW, ST_T_W,
		ST_VIEW, ST_V_F, ST_V_S, ST_V_U, ST_V_D0, ST_V_D1, ST_V_D2, ST_OUT,
		ST_PR_MUL, ST_PR_ACC,
		ST_N_ABS, ST_N_SHIFT, ST_N_ROOT, ST_N_SQRT, ST_N_DIVL, ST_N_DIV, ST_N_DIVS,
		ST_S_PREP, ST_S_MOD, ST_S_FOLD, ST_S_ROT, ST_S_END
	} state_t;

	state_t state_q, pr_ret_q, norm_ret_q, sc_ret_q;

	// pose and configuration
	logic signed [31:0] pos_q [3];
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] front_q [3];
	logic signed [31:0] right_q [3];
	logic signed [31:0] up_q [3];

	// event fields
	op_t                op_q;
	logic [1:0]         dir_q;
	logic signed [31:0] yaw_q;

	// product sequencer
	pmode_t             pr_mode_q;
	logic [2:0]         pc_q;
	logic signed [31:0] va_q [3];
	logic signed [31:0] vb_q [3];
	logic signed [63:0] prod_q;
	logic [63:0]        acc_q;
	logic signed [63:0] w_q [3];

	// normalizer
	logic [63:0]        nm_q [3];
	logic [2:0]         neg_q;
	logic [63:0]        sq_n_q, sq_res_q, sq_bit_q;
	logic [NW-1:0]      dn_q;
	logic [QW-1:0]      dq_q;
	logic [IW-1:0]      di_q;
	logic [1:0]         nk_q;
	logic signed [31:0] n_q [3];

	// sine and cosine
	logic signed [31:0] sc_ang_q;
	logic [27:0]        hm_q;
	logic [26:0]        low_q;
	logic [4:0]         mk_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0]         ci_q;
	logic               flip_q;
	logic signed [31:0] cos_q, sin_q, cp_q, sp_q;

	// view rows
	logic signed [31:0] f_q [3];
	logic signed [31:0] s_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] sh_q [3];

	logic               m_tvalid_q;
	logic [383:0]       m_tdata_q;

	// request fields
	logic [1:0]         in_op, in_dir;
	logic signed [31:0] in_speed, in_pitch, in_yaw, pitch_clamped;
	logic signed [31:0] in_pos [3];
	logic signed [31:0] in_aim [3];
	logic               accept;

	always_comb begin
		in_op    = s_tuser[1:0];
		in_dir   = s_tuser[3:2];
		in_speed = s_tdata[31:0];
		in_pitch = s_tdata[63:32];
		in_yaw   = s_tdata[95:64];
		for (int k = 0; k < 3; k++) begin
			in_pos[k] = s_tdata[96 + 32 * k +: 32];
			in_aim[k] = s_tdata[192 + 32 * k +: 32];
		end
		if (in_pitch > PITCH_LIM)
			pitch_clamped = PITCH_LIM;
		else if (in_pitch < -PITCH_LIM)
			pitch_clamped = -PITCH_LIM;
		else
			pitch_clamped = in_pitch;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// shared multiplier operands and rounding
	logic [1:0]         ia, ib;
	logic signed [31:0] opa, opb;
	logic signed [63:0] prod_d, qsum, qr, move_sum;
	logic               move_back;

	always_comb begin
		if (pr_mode_q == PM_CROSS) begin
			ia = cross_a_idx(pc_q);
			ib = cross_b_idx(pc_q);
		end else begin
			ia = pc_q[1:0];
			ib = pc_q[1:0];
		end
		if (pr_mode_q == PM_SQR) begin
			opa = nm_q[ia][31:0];
			opb = nm_q[ib][31:0];
		end else begin
			opa = va_q[ia];
			opb = vb_q[ib];
		end
		prod_d    = opa * opb;
		qsum      = prod_q + RND_HALF;
		qr        = qsum >>> FRAC_BITS;
		move_back = (dir_q == DIR_BACK) || (dir_q == DIR_LEFT);
		move_sum  = move_back ? pos_q[pc_q[1:0]] - qr : pos_q[pc_q[1:0]] + qr;
	end

	// normalizer datapath
	logic               shift_any, sq_ge, div_ge, len_zero;
	logic [63:0]        sq_trial;
	logic [NW-1:0]      div_sub;
	logic [QW-1:0]      dq_fix;
	logic signed [31:0] qv;

	always_comb begin
		shift_any = (|nm_q[0][63:31]) || (|nm_q[1][63:31]) || (|nm_q[2][63:31]);
		sq_trial  = sq_res_q + sq_bit_q;
		sq_ge     = sq_n_q >= sq_trial;
		div_sub   = NW'(sq_res_q[31:0]) << di_q;
		div_ge    = dn_q >= div_sub;
		len_zero  = (sq_res_q[31:0] == 32'd0);
		dq_fix    = len_zero ? '0 : dq_q;
		qv        = 32'(dq_fix);
	end

	// angle reduction and CORDIC datapath
	logic signed [47:0] z48;
	logic [27:0]        hm_init, mod_sub;
	logic signed [33:0] zr0, zr1, zr2, cdx, cdy, catan, ncx, ncy;
	logic               zr_flip;

	always_comb begin
		z48     = 48'(sc_ang_q) <<< ANG_SHIFT;
		hm_init = 28'(signed'(z48[47:27])) + MOD_BIAS;
		mod_sub = 28'(MOD_BASE) << mk_q;
		zr0     = signed'({1'b0, hm_q[5:0], low_q});
		zr1     = (zr0 >= TURN_HALF) ? zr0 - TURN_FULL : zr0;
		zr_flip = 1'b0;
		zr2     = zr1;
		if (zr1 > TURN_QUART) begin
			zr2     = zr1 - TURN_HALF;
			zr_flip = 1'b1;
		end else if (zr1 < -TURN_QUART) begin
			zr2     = zr1 + TURN_HALF;
			zr_flip = 1'b1;
		end
		cdx   = cy_q >>> ci_q;
		cdy   = cx_q >>> ci_q;
		catan = signed'({2'b00, atan_deg(ci_q)});
		ncx   = -cx_q;
		ncy   = -cy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pr_ret_q   <= ST_IDLE;
			norm_ret_q <= ST_IDLE;
			sc_ret_q   <= ST_IDLE;
			for (int k = 0; k < 3; k++) begin
				pos_q[k]   <= '0;
				tgt_q[k]   <= '0;
				front_q[k] <= '0;
				right_q[k] <= '0;
				up_q[k]    <= '0;
				va_q[k]    <= '0;
				vb_q[k]    <= '0;
				w_q[k]     <= '0;
				nm_q[k]    <= '0;
				n_q[k]     <= '0;
				f_q[k]     <= '0;
				s_q[k]     <= '0;
				u_q[k]     <= '0;
				sh_q[k]    <= '0;
			end
			tgt_q[2]   <= -ONE;
			front_q[2] <= -ONE;
			right_q[0] <= ONE;
			up_q[1]    <= ONE;
			op_q       <= OP_VIEW;
			dir_q      <= DIR_FWD;
			yaw_q      <= '0;
			pr_mode_q  <= PM_DOT;
			pc_q       <= '0;
			prod_q     <= '0;
			acc_q      <= '0;
			neg_q      <= '0;
			sq_n_q     <= '0;
			sq_res_q   <= '0;
			sq_bit_q   <= '0;
			dn_q       <= '0;
			dq_q       <= '0;
			di_q       <= '0;
			nk_q       <= '0;
			sc_ang_q   <= '0;
			hm_q       <= '0;
			low_q      <= '0;
			mk_q       <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			cz_q       <= '0;
			ci_q       <= '0;
			flip_q     <= 1'b0;
			cos_q      <= '0;
			sin_q      <= '0;
			cp_q       <= '0;
			sp_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// up vector writes; an index past up_z is dropped
			if (cfg_we) begin
				unique case (cfg_index)
					2'd0:    up_q[0] <= cfg_data;
					2'd1:    up_q[1] <= cfg_data;
					2'd2:    up_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// free the output slot once the receiver takes it
			if (m_tvalid_q && m_tready && (state_q != ST_OUT))
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= op_t'(in_op);
						dir_q <= in_dir;
						yaw_q <= in_yaw;
						unique case (op_t'(in_op))
							OP_PLACE: begin
								for (int k = 0; k < 3; k++) begin
									pos_q[k] <= in_pos[k];
									tgt_q[k] <= in_aim[k];
									w_q[k]   <= 64'(in_aim[k]) - 64'(in_pos[k]);
								end
								norm_ret_q <= ST_P_FRONT;
								state_q    <= ST_N_ABS;
							end
							OP_MOVE: begin
								for (int k = 0; k < 3; k++) begin
									va_q[k] <= ((in_dir == DIR_FWD) || (in_dir == DIR_BACK)) ?
										front_q[k] : right_q[k];
									vb_q[k] <= in_speed;
								end
								pr_mode_q <= PM_MOVE;
								pc_q      <= '0;
								pr_ret_q  <= ST_AIM;
								state_q   <= ST_PR_MUL;
							end
							OP_ROTATE: begin
								sc_ang_q <= pitch_clamped;
								sc_ret_q <= ST_T_YAW;
								state_q  <= ST_S_PREP;
							end
							default: state_q <= ST_VIEW;
						endcase
					end
				end

				// pose updates
				ST_P_FRONT: begin
					for (int k = 0; k < 3; k++) begin
						front_q[k] <= n_q[k];
						va_q[k]    <= n_q[k];
						vb_q[k]    <= up_q[k];
					end
					pr_mode_q  <= PM_CROSS;
					pc_q       <= '0;
					pr_ret_q   <= ST_N_ABS;
					norm_ret_q <= ST_R_DONE;
					state_q    <= ST_PR_MUL;
				end
				ST_R_DONE: begin
					for (int k = 0; k < 3; k++)
						right_q[k] <= n_q[k];
					state_q <= (op_q == OP_ROTATE) ? ST_AIM : ST_VIEW;
				end
				ST_AIM: begin
					for (int k = 0; k < 3; k++)
						tgt_q[k] <= sat32(64'(pos_q[k]) + 64'(front_q[k]));
					state_q <= ST_VIEW;
				end
				ST_T_YAW: begin
					cp_q     <= cos_q;
					sp_q     <= sin_q;
					sc_ang_q <= yaw_q;
					sc_ret_q <= ST_T_W;
					state_q  <= ST_S_PREP;
				end
				ST_T_W: begin
					va_q[0] <= cos_q;
					va_q[1] <= '0;
					va_q[2] <= sin_q;
					for (int k = 0; k < 3; k++)
						vb_q[k] <= cp_q;
					w_q[1]     <= 64'(sp_q) <<< VEC_BITS;
					pr_mode_q  <= PM_ROT;
					pc_q       <= '0;
					pr_ret_q   <= ST_N_ABS;
					norm_ret_q <= ST_P_FRONT;
					state_q    <= ST_PR_MUL;
				end

				// view matrix rows
				ST_VIEW: begin
					for (int k = 0; k < 3; k++)
						w_q[k] <= 64'(tgt_q[k]) - 64'(pos_q[k]);
					norm_ret_q <= ST_V_F;
					state_q    <= ST_N_ABS;
				end
				ST_V_F: begin
					for (int k = 0; k < 3; k++) begin
						f_q[k]  <= n_q[k];
						va_q[k] <= n_q[k];
						vb_q[k] <= up_q[k];
					end
					pr_mode_q  <= PM_CROSS;
					pc_q       <= '0;
					pr_ret_q   <= ST_N_ABS;
					norm_ret_q <= ST_V_S;
					state_q    <= ST_PR_MUL;
				end
				ST_V_S: begin
					for (int k = 0; k < 3; k++) begin
						s_q[k]  <= n_q[k];
						va_q[k] <= n_q[k];
						vb_q[k] <= f_q[k];
					end
					pr_mode_q <= PM_CROSS;
					pc_q      <= '0;
					pr_ret_q  <= ST_V_U;
					state_q   <= ST_PR_MUL;
				end
				ST_V_U: begin
					for (int k = 0; k < 3; k++) begin
						u_q[k]  <= sat32(w_q[k]);
						va_q[k] <= s_q[k];
						vb_q[k] <= pos_q[k];
					end
					pr_mode_q <= PM_DOT;
					pc_q      <= '0;
					pr_ret_q  <= ST_V_D0;
					state_q   <= ST_PR_MUL;
				end
				ST_V_D0: begin
					sh_q[0] <= sat32(-signed'(acc_q));
					for (int k = 0; k < 3; k++)
						va_q[k] <= u_q[k];
					pc_q     <= '0;
					pr_ret_q <= ST_V_D1;
					state_q  <= ST_PR_MUL;
				end
				ST_V_D1: begin
					sh_q[1] <= sat32(-signed'(acc_q));
					for (int k = 0; k < 3; k++)
						va_q[k] <= f_q[k];
					pc_q     <= '0;
					pr_ret_q <= ST_V_D2;
					state_q  <= ST_PR_MUL;
				end
				ST_V_D2: begin
					sh_q[2] <= sat32(signed'(acc_q));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output slot is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {sh_q[2], -f_q[2], -f_q[1], -f_q[0],
							sh_q[1], u_q[2], u_q[1], u_q[0],
							sh_q[0], s_q[2], s_q[1], s_q[0]};
						state_q    <= ST_IDLE;
					end
				end

				// shared multiplier sequence
				ST_PR_MUL: begin
					prod_q  <= prod_d;
					state_q <= ST_PR_ACC;
				end
				ST_PR_ACC: begin
					unique case (pr_mode_q)
						PM_CROSS: begin
							if (!pc_q[0])
								w_q[pc_q[2:1]] <= qr;
							else
								w_q[pc_q[2:1]] <= w_q[pc_q[2:1]] - qr;
						end
						PM_DOT:  acc_q <= (pc_q == 3'd0) ? qr : acc_q + qr;
						PM_SQR:  acc_q <= (pc_q == 3'd0) ? prod_q : acc_q + prod_q;
						PM_MOVE: pos_q[pc_q[1:0]] <= sat32(move_sum);
						default: begin
							if (pc_q != 3'd1)
								w_q[pc_q[1:0]] <= prod_q;
						end
					endcase
					if ((pr_mode_q == PM_CROSS) ? (pc_q == 3'd5) : (pc_q == 3'd2)) begin
						state_q <= pr_ret_q;
					end else begin
						pc_q    <= pc_q + 3'd1;
						state_q <= ST_PR_MUL;
					end
				end

				// normalize w_q into n_q
				ST_N_ABS: begin
					for (int k = 0; k < 3; k++) begin
						nm_q[k]  <= w_q[k][63] ? 64'(-w_q[k]) : 64'(w_q[k]);
						neg_q[k] <= w_q[k][63];
					end
					state_q <= ST_N_SHIFT;
				end
				ST_N_SHIFT: begin
					// shift all three down together until every magnitude fits 31 bits
					if (shift_any) begin
						for (int k = 0; k < 3; k++)
							nm_q[k] <= nm_q[k] >> 1;
					end else begin
						pr_mode_q <= PM_SQR;
						pc_q      <= '0;
						pr_ret_q  <= ST_N_ROOT;
						state_q   <= ST_PR_MUL;
					end
				end
				ST_N_ROOT: begin
					sq_n_q   <= acc_q;
					sq_res_q <= '0;
					sq_bit_q <= 64'd1 << 62;
					state_q  <= ST_N_SQRT;
				end
				ST_N_SQRT: begin
					if (sq_ge) begin
						sq_n_q   <= sq_n_q - sq_trial;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						nk_q    <= '0;
						state_q <= ST_N_DIVL;
					end
				end
				ST_N_DIVL: begin
					dn_q    <= (NW'(nm_q[nk_q]) << FRAC_BITS) + NW'(sq_res_q[31:1]);
					dq_q    <= '0;
					di_q    <= IW'(FRAC_BITS);
					state_q <= ST_N_DIV;
				end
				ST_N_DIV: begin
					if (div_ge)
						dn_q <= dn_q - div_sub;
					dq_q <= {dq_q[QW-2:0], div_ge};
					if (di_q == '0)
						state_q <= ST_N_DIVS;
					else
						di_q <= di_q - IW'(1);
				end
				ST_N_DIVS: begin
					// zero length leaves the zero vector
					n_q[nk_q] <= neg_q[nk_q] ? -qv : qv;
					if (nk_q == 2'd2) begin
						state_q <= norm_ret_q;
					end else begin
						nk_q    <= nk_q + 2'd1;
						state_q <= ST_N_DIVL;
					end
				end

				// sine and cosine of sc_ang_q
				ST_S_PREP: begin
					hm_q    <= hm_init;
					low_q   <= z48[26:0];
					mk_q    <= 5'd21;
					state_q <= ST_S_MOD;
				end
				ST_S_MOD: begin
					if (hm_q >= mod_sub)
						hm_q <= hm_q - mod_sub;
					if (mk_q == 5'd0)
						state_q <= ST_S_FOLD;
					else
						mk_q <= mk_q - 5'd1;
				end
				ST_S_FOLD: begin
					cz_q    <= zr2;
					flip_q  <= zr_flip;
					cx_q    <= CORDIC_GAIN;
					cy_q    <= '0;
					ci_q    <= '0;
					state_q <= ST_S_ROT;
				end
				ST_S_ROT: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - cdx;
						cy_q <= cy_q + cdy;
						cz_q <= cz_q - catan;
					end else begin
						cx_q <= cx_q + cdx;
						cy_q <= cy_q - cdy;
						cz_q <= cz_q + catan;
					end
					if (ci_q == 5'(CORDIC_STEPS - 1))
						state_q <= ST_S_END;
					else
						ci_q <= ci_q + 5'd1;
				end
				ST_S_END: begin
					cos_q   <= flip_q ? ncx[31:0] : cx_q[31:0];
					sin_q   <= flip_q ? ncy[31:0] : cy_q[31:0];
					state_q <= sc_ret_q;
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CPV_ASSERT_NXT(a_busy_after_req, clk, arst_n, accept, !s_tready)
	`CPV_ASSERT_IMP(a_unit_bound, clk, arst_n, (state_q == ST_N_DIVS) && !len_zero, dq_q <= (QW'(1) << FRAC_BITS))
	`CPV_ASSERT_IMP(a_cordic_count, clk, arst_n, state_q == ST_S_ROT, ci_q < 5'(CORDIC_STEPS))
	`CPV_ASSERT_NXT(a_hold_result, clk, arst_n, (state_q == ST_OUT) && m_tvalid && !m_tready, state_q == ST_OUT)

endmodule

`default_nettype wire

// ----- dv/cpv_view_checker.sv -----
// Checker for camera_pose_view_matrix: tracks the pose and world up vector,
// predicts each view matrix and compares it with the results. Depends on cpv_pkg.
`timescale 1ns / 1ps

module cpv_view_checker
	import cpv_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [3:0]   s_tuser,
	input  wire logic [287:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [383:0] m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                fails,
	output int                pending
);

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint ATAN_TAB [24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	int pos [3];
	int aim [3];
	int fwd [3];
	int rgt [3];
	int up [3];
	logic [383:0] rows_due [$];

	function automatic int clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// a zero vector stays zero
	function automatic void unit3(input longint v [3], output int o [3]);
		longint unsigned m [3];
		longint unsigned top, sum, len;
		int q;
		top = 0;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = (v[k] < 0) ? longint'(-v[k]) : v[k];
			if (m[k] > top) top = m[k];
		end
		while (top >= 64'h8000_0000) begin
			top >>= 1;
			for (int k = 0; k < 3; k++) m[k] >>= 1;
		end
		for (int k = 0; k < 3; k++) sum += m[k] * m[k];
		len = root64(sum);
		for (int k = 0; k < 3; k++) begin
			q = 0;
			if (len != 0) q = int'(((m[k] << FRAC_BITS) + len / 2) / len);
			o[k] = (v[k] < 0) ? -q : q;
		end
	endfunction

	function automatic void cross3(input int a [3], input int b [3], output longint o [3]);
		o[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
		o[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
		o[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
	endfunction

	function automatic longint dot3(input int a [3], input int b [3]);
		return fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
	endfunction

	// CORDIC in degrees, 24 fraction bits of angle, 30 of vector
	function automatic void sin_cos(input longint deg, output longint c, output longint s);
		longint full, half, quart, z, x, y, dx, dy;
		bit flip;
		full = longint'(360) << 24;
		half = longint'(180) << 24;
		quart = longint'(90) << 24;
		z = deg * (longint'(1) << (24 - FRAC_BITS));
		x = 652032874;
		y = 0;
		flip = 0;
		z = z % full;
		if (z < 0) z += full;
		if (z >= half) z -= full;
		if (z > quart) begin
			z -= half;
			flip = 1;
		end else if (z < -quart) begin
			z += half;
			flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TAB[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TAB[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void update_right();
		longint w [3];
		cross3(fwd, up, w);
		unit3(w, rgt);
	endfunction

	function automatic void aim_ahead();
		for (int k = 0; k < 3; k++) aim[k] = clip32(longint'(pos[k]) + fwd[k]);
	endfunction

	// apply one camera event, return the packed view matrix it yields
	function automatic logic [383:0] pose_event(input logic [3:0] user, input logic [287:0] d);
		op_t op;
		logic [1:0] dir;
		longint w [3];
		longint step, pitch, cp, sp, cy, sy, lim;
		int f [3];
		int s [3];
		int u [3];
		logic [383:0] r;
		op = op_t'(user[1:0]);
		dir = user[3:2];
		case (op)
			OP_PLACE: begin
				for (int k = 0; k < 3; k++) begin
					pos[k] = int'(d[96 + 32*k +: 32]);
					aim[k] = int'(d[192 + 32*k +: 32]);
					w[k] = longint'(aim[k]) - pos[k];
				end
				unit3(w, fwd);
				update_right();
			end
			OP_MOVE: begin
				for (int k = 0; k < 3; k++) begin
					step = fx_mul((dir == DIR_FWD || dir == DIR_BACK) ? fwd[k] : rgt[k],
						int'(d[31:0]));
					if (dir == DIR_BACK || dir == DIR_LEFT)
						pos[k] = clip32(longint'(pos[k]) - step);
					else
						pos[k] = clip32(longint'(pos[k]) + step);
				end
				aim_ahead();
			end
			OP_ROTATE: begin
				lim = longint'(PITCH_LIMIT_DEG) << FRAC_BITS;
				pitch = int'(d[63:32]);
				if (pitch > lim) pitch = lim;
				if (pitch < -lim) pitch = -lim;
				sin_cos(pitch, cp, sp);
				sin_cos(longint'(int'(d[95:64])), cy, sy);
				w[0] = cy * cp;
				w[1] = sp * (longint'(1) << 30);
				w[2] = sy * cp;
				unit3(w, fwd);
				update_right();
				aim_ahead();
			end
			default: ;
		endcase
		for (int k = 0; k < 3; k++) w[k] = longint'(aim[k]) - pos[k];
		unit3(w, f);
		cross3(f, up, w);
		unit3(w, s);
		cross3(s, f, w);
		for (int k = 0; k < 3; k++) u[k] = clip32(w[k]);
		for (int k = 0; k < 3; k++) begin
			r[32*k +: 32] = s[k];
			r[128 + 32*k +: 32] = u[k];
			r[256 + 32*k +: 32] = -f[k];
		end
		r[96 +: 32] = clip32(-dot3(s, pos));
		r[224 +: 32] = clip32(-dot3(u, pos));
		r[352 +: 32] = clip32(dot3(f, pos));
		return r;
	endfunction

	assign pending = rows_due.size();

	always @(posedge clk or negedge arst_n) begin
		logic [383:0] want;
		if (!arst_n) begin
			pos = '{0, 0, 0};
			aim = '{0, 0, -ONE};
			fwd = '{0, 0, -ONE};
			rgt = '{ONE, 0, 0};
			up = '{0, ONE, 0};
			rows_due.delete();
			fails = 0;
		end else begin
			if (cfg_we && cfg_index != 2'd3) up[cfg_index] = int'(cfg_data);
			if (m_tvalid && m_tready) begin
				if (rows_due.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected result %h", m_tdata);
				end else begin
					want = rows_due.pop_front();
					for (int k = 0; k < 12; k++)
						if (want[32*k +: 32] !== m_tdata[32*k +: 32]) begin
							fails++;
							if (fails <= 10)
								$display("field %0d: expected %h, got %h", k,
									want[32*k +: 32], m_tdata[32*k +: 32]);
						end
				end
			end
			if (s_tvalid && s_tready) rows_due.push_back(pose_event(s_tuser, s_tdata));
		end
	end

endmodule

// ----- dv/tb_camera_pose_view_matrix.sv -----
// Top of the camera_pose_view_matrix testbench: clock, reset, event and up
// vector stimulus, verdict. Depends on cpv_pkg and cpv_view_checker.
`timescale 1ns / 1ps

module tb_camera_pose_view_matrix;
	import cpv_pkg::*;

	localparam int  STALL_LIMIT = 20000;	// idle cycles before giving up
	localparam int  DRAIN_WAIT  = 800;
	localparam int  ONE         = 65536;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [3:0]   s_tuser = '0;	// [1:0] op, [3:2] move_dir
	logic [287:0] s_tdata = '0;	// speed, pitch, yaw, pos_x..z, aim_x..z (32 bits each)
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [383:0] m_tdata;	// side_x..z, side_shift, lift_x..z, lift_shift, back_x..z, back_shift
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	int           fails;
	int           pending;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	int           quiet = 0;

	always #5 clk = ~clk;

	camera_pose_view_matrix DUT (.*);

	cpv_view_checker chk (.*);

	// receiver: random backpressure, decided on the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// watchdog: count cycles where no request moves on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// hold the event until the block takes it, then advance to the falling edge
	task automatic send_event(input op_t op, input logic [1:0] dir, input logic [287:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tuser <= {dir, op};
		s_tdata <= d;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drain every pending result, then write the world up vector plus a dropped index
	task automatic set_up(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		s_tvalid <= 0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= 2'd0;
		cfg_data <= x;
		@(negedge clk);
		cfg_index <= 2'd1;
		cfg_data <= y;
		@(negedge clk);
		cfg_index <= 2'd2;
		cfg_data <= z;
		@(negedge clk);
		cfg_index <= 2'd3;
		cfg_data <= $urandom;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// mostly moderate coordinates, sometimes full range or the extremes
	function automatic logic [31:0] rand_q16();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			2: return $urandom_range(0, 8 * ONE) - 4 * ONE;
			default: return $urandom_range(0, 2000 * ONE) - 1000 * ONE;
		endcase
	endfunction

	function automatic logic [287:0] rand_fields();
		logic [287:0] d;
		for (int k = 0; k < 9; k++) d[32*k +: 32] = rand_q16();
		// mostly sane angles so rotate stays near the clamp region
		if ($urandom_range(3) != 0) d[63:32] = $urandom_range(0, 240 * ONE) - 120 * ONE;
		if ($urandom_range(3) != 0) d[95:64] = $urandom_range(0, 720 * ONE) - 360 * ONE;
		return d;
	endfunction

	function automatic logic [287:0] pack_fields(input logic [31:0] spd, input logic [31:0] pit,
			input logic [31:0] yw, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az);
		return {az, ay, ax, pz, py, px, yw, pit, spd};
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: reset pose view, degenerate and extreme poses
		send_event(OP_VIEW, DIR_FWD, '1);
		send_event(OP_PLACE, DIR_FWD, pack_fields(0, 0, 0, 5 * ONE, 5 * ONE, 5 * ONE,
			5 * ONE, 5 * ONE, 5 * ONE));	// target on position: zero look vector
		send_event(OP_PLACE, DIR_FWD, pack_fields(0, 0, 0, 0, 0, 0, 0, 7 * ONE, 0));	// look along up
		send_event(OP_VIEW, DIR_FWD, '0);
		send_event(OP_PLACE, DIR_FWD, pack_fields(0, 0, 0, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		send_event(OP_MOVE, DIR_FWD, pack_fields(32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_MOVE, DIR_BACK, pack_fields(32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_PLACE, DIR_FWD, pack_fields(0, 0, 0, ONE, 2 * ONE, 3 * ONE,
			-4 * ONE, ONE, -2 * ONE));
		send_event(OP_MOVE, DIR_FWD, pack_fields(3 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_MOVE, DIR_BACK, pack_fields(ONE / 2, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_MOVE, DIR_RIGHT, pack_fields(2 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_MOVE, DIR_LEFT, pack_fields(-5 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, 120 * ONE, 30 * ONE, 0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, -95 * ONE, 90 * ONE, 0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, 32'h7fffffff, 32'h7fffffff,
			0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, 32'h80000000, 32'h80000000,
			0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, 89 * ONE, 180 * ONE, 0, 0, 0, 0, 0, 0));
		send_event(OP_ROTATE, DIR_FWD, pack_fields(0, 0, -90 * ONE, 0, 0, 0, 0, 0, 0));
		send_event(OP_MOVE, DIR_RIGHT, pack_fields(32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0));

		// random: six segments, each under a different up vector
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: set_up(0, 0, ONE);
				1: set_up(32'h7fffffff, 32'h80000000, 32'h7fffffff);
				2: set_up($urandom, $urandom, $urandom);
				3: set_up(0, 0, 0);	// zero up: every side row collapses
				4: set_up(32'h80000000, 32'h7fffffff, 32'h80000000);
				default: set_up(-ONE / 3, 2 * ONE, ONE / 5);
			endcase
			tx_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 58 : 0;
			rx_idle_pct = (seg < 2) ? 58 : (seg < 4) ? 23 : 0;
			for (int n = 0; n < 315; n++)
				send_event(op_t'($urandom_range(3)), 2'($urandom_range(3)), rand_fields());
		end
		s_tvalid <= 0;

		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cpv_pkg.sv
rtl/camera_pose_view_matrix.sv
dv/cpv_view_checker.sv
dv/tb_camera_pose_view_matrix.sv
